// ===== sv/rpnsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RPN calculator package
// Command and status codes, shared types and state encodings.
// ----------------------------------------------------------------------------
package rpnsc_pkg;

	localparam int DATA_W   = 32;
	localparam int CNT_W    = 5;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 3;

	localparam logic [KIND_W-1:0] CMD_PUSH = 3'd0;
	localparam logic [KIND_W-1:0] CMD_POP  = 3'd1;
	localparam logic [KIND_W-1:0] CMD_ADD  = 3'd2;
	localparam logic [KIND_W-1:0] CMD_SUB  = 3'd3;
	localparam logic [KIND_W-1:0] CMD_MUL  = 3'd4;
	localparam logic [KIND_W-1:0] CMD_DIV  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TWO     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_FIX_A,
		A_FIX_B,
		A_STEP,
		A_FIX_R,
		A_DONE
	} alu_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP_RD,
		S_RD_B,
		S_RD_A,
		S_ALU,
		S_RESP
	} seq_state_t;

endpackage
`default_nettype wire

// ===== sv/rpnsc_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RPN calculator operand stack
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module rpnsc_stack #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [rpnsc_pkg::DATA_W-1:0]  wr_data,
	input  wire logic                          rd_en,
	input  wire logic [AW-1:0]                 rd_addr,
	output logic      [rpnsc_pkg::DATA_W-1:0]  rd_data
);
	import rpnsc_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== sv/rpnsc_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RPN calculator arithmetic unit
// One shared 33-bit adder: add/subtract in one step, shift-add multiply and
// restoring divide one bit per cycle, with sign fix-up passes for divide.
// ----------------------------------------------------------------------------
module rpnsc_alu (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rpnsc_pkg::alu_req_t           req,
	input  wire logic [rpnsc_pkg::DATA_W-1:0]  a,
	input  wire logic [rpnsc_pkg::DATA_W-1:0]  b,
	output logic                               done,
	output logic      [rpnsc_pkg::DATA_W-1:0]  result
);
	import rpnsc_pkg::*;

	alu_state_t        state_q, state_d;
	alu_op_t           op_q;
	logic [DATA_W-1:0] x_q, y_q, acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;

	logic [DATA_W:0]   ax, ay;
	logic              sub;
	logic [DATA_W+1:0] sum;
	logic              last_step;

	always_comb begin
		ax  = '0;
		ay  = '0;
		sub = 1'b0;
		unique case (state_q)
			A_FIX_A: begin
				ay  = {1'b0, x_q};
				sub = 1'b1;
			end
			A_FIX_B: begin
				ay  = {1'b0, y_q};
				sub = 1'b1;
			end
			A_FIX_R: begin
				ay  = {1'b0, x_q};
				sub = 1'b1;
			end
			A_STEP: begin
				unique case (op_q)
					ALU_ADD: begin
						ax = {1'b0, x_q};
						ay = {1'b0, y_q};
					end
					ALU_SUB: begin
						ax  = {1'b0, x_q};
						ay  = {1'b0, y_q};
						sub = 1'b1;
					end
					ALU_MUL: begin
						ax = {1'b0, acc_q};
						ay = {1'b0, x_q};
					end
					ALU_DIV: begin
						ax  = {acc_q, x_q[DATA_W-1]};
						ay  = {1'b0, y_q};
						sub = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign sum = {1'b0, ax} + {1'b0, ay ^ {(DATA_W+1){sub}}} + {{(DATA_W+1){1'b0}}, sub};
	assign last_step = (cnt_q == {CNT_W{1'b1}});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					state_d = (req.op == ALU_DIV) ? A_FIX_A : A_STEP;
				end
			end
			A_FIX_A: state_d = A_FIX_B;
			A_FIX_B: state_d = A_STEP;
			A_STEP: begin
				if (op_q == ALU_ADD || op_q == ALU_SUB) begin
					state_d = A_DONE;
				end else if (last_step) begin
					state_d = (op_q == ALU_DIV) ? A_FIX_R : A_DONE;
				end
			end
			A_FIX_R: state_d = A_DONE;
			A_DONE:  state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == A_DONE);
		result = (op_q == ALU_DIV) ? x_q : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == A_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == A_STEP) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					x_q   <= a;
					y_q   <= b;
					acc_q <= '0;
					neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
				end
			end
			A_FIX_A: begin
				if (x_q[DATA_W-1]) begin
					x_q <= sum[DATA_W-1:0];
				end
			end
			A_FIX_B: begin
				if (y_q[DATA_W-1]) begin
					y_q <= sum[DATA_W-1:0];
				end
			end
			A_STEP: begin
				unique case (op_q)
					ALU_ADD, ALU_SUB: acc_q <= sum[DATA_W-1:0];
					ALU_MUL: begin
						if (y_q[0]) begin
							acc_q <= sum[DATA_W-1:0];
						end
						x_q <= {x_q[DATA_W-2:0], 1'b0};
						y_q <= {1'b0, y_q[DATA_W-1:1]};
					end
					ALU_DIV: begin
						acc_q <= sum[DATA_W+1] ? sum[DATA_W-1:0]
						                       : {acc_q[DATA_W-2:0], x_q[DATA_W-1]};
						x_q   <= {x_q[DATA_W-2:0], sum[DATA_W+1]};
					end
					default: ;
				endcase
			end
			A_FIX_R: begin
				if (neg_q) begin
					x_q <= sum[DATA_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/rpn_stack_calculator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Reverse-Polish integer calculator: push, pop and four operators on a
// bounded operand stack, one result transaction per command.
// ----------------------------------------------------------------------------
// Push, unused codes and stack errors respond straight from decode; pop reads
// the top entry first; the operators read both operands and run the
// arithmetic unit, but divide by zero responds without starting it.
// One command at a time; the next is taken the cycle after the result leaves.
// Multiply and divide step the shared adder one bit per cycle.
// Reset clears the entry count and control; stack memory is left uncleared.
module rpn_stack_calculator_core #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [rpnsc_pkg::KIND_W-1:0]        kind,
	input  wire logic signed [rpnsc_pkg::DATA_W-1:0] operand_value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [rpnsc_pkg::STATUS_W-1:0]      status,
	output logic                                     answer_valid,
	output logic signed [rpnsc_pkg::DATA_W-1:0]      answer_value,
	output logic      [$clog2(STACK_DEPTH+1)-1:0]    stack_depth
);
	import rpnsc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	seq_state_t          state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [KIND_W-1:0]   kind_q;
	logic [DATA_W-1:0]   value_q;
	logic [DATA_W-1:0]   b_q;
	logic [STATUS_W-1:0] status_q;
	logic                ans_valid_q;
	logic [DATA_W-1:0]   ans_q;

	logic                accept;
	logic                is_op, full, empty, short, div_zero;
	logic [CW-1:0]       cnt_m1, cnt_m2;

	logic                mem_wr_en, mem_rd_en;
	logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
	logic [DATA_W-1:0]   mem_wr_data, mem_rd_data;

	alu_req_t            alu_req;
	logic                alu_done;
	logic [DATA_W-1:0]   alu_result;

	rpnsc_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	rpnsc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (mem_rd_data),
		.b      (b_q),
		.done   (alu_done),
		.result (alu_result)
	);

	assign accept   = in_valid && !in_stall;
	assign is_op    = (kind_q == CMD_ADD) || (kind_q == CMD_SUB) ||
	                  (kind_q == CMD_MUL) || (kind_q == CMD_DIV);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign short    = (count_q < CW'(2));
	assign div_zero = (kind_q == CMD_DIV) && (b_q == '0);
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (kind_q == CMD_PUSH) begin
					state_d = S_RESP;
					if (!full) begin
						count_d = count_q + CW'(1);
					end
				end else if (kind_q == CMD_POP) begin
					state_d = empty ? S_RESP : S_POP_RD;
				end else if (is_op) begin
					state_d = short ? S_RESP : S_RD_B;
				end else begin
					state_d = S_RESP;
				end
			end
			S_POP_RD: begin
				state_d = S_RESP;
				count_d = cnt_m1;
			end
			S_RD_B: state_d = S_RD_A;
			S_RD_A: state_d = div_zero ? S_RESP : S_ALU;
			S_ALU: begin
				if (alu_done) begin
					state_d = S_RESP;
					count_d = cnt_m1;
				end
			end
			S_RESP: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = (state_q != S_IDLE);
		out_valid   = (state_q == S_RESP);
		mem_wr_en   = 1'b0;
		mem_wr_addr = count_q[AW-1:0];
		mem_wr_data = value_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = cnt_m1[AW-1:0];
		alu_req     = '{start: 1'b0, op: ALU_ADD};
		unique case (kind_q)
			CMD_SUB: alu_req.op = ALU_SUB;
			CMD_MUL: alu_req.op = ALU_MUL;
			CMD_DIV: alu_req.op = ALU_DIV;
			default: alu_req.op = ALU_ADD;
		endcase
		unique case (state_q)
			S_DECODE: begin
				mem_wr_en = (kind_q == CMD_PUSH) && !full;
				mem_rd_en = 1'b1;
			end
			S_RD_B: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = cnt_m2[AW-1:0];
			end
			S_RD_A: alu_req.start = !div_zero;
			S_ALU: begin
				mem_wr_en   = alu_done;
				mem_wr_addr = cnt_m2[AW-1:0];
				mem_wr_data = alu_result;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q  <= kind;
					value_q <= operand_value;
				end
			end
			S_DECODE: begin
				ans_valid_q <= 1'b0;
				ans_q       <= '0;
				priority if (kind_q == CMD_PUSH && full) begin
					status_q <= ST_FULL;
				end else if (kind_q == CMD_POP && empty) begin
					status_q <= ST_EMPTY;
				end else if (is_op && short) begin
					status_q <= ST_TWO;
				end else begin
					status_q <= ST_OK;
				end
			end
			S_POP_RD: begin
				ans_valid_q <= 1'b1;
				ans_q       <= mem_rd_data;
			end
			S_RD_B: b_q <= mem_rd_data;
			S_RD_A: begin
				if (div_zero) begin
					status_q <= ST_DIVZERO;
				end
			end
			S_ALU: begin
				if (alu_done) begin
					ans_valid_q <= 1'b1;
					ans_q       <= alu_result;
				end
			end
			default: ;
		endcase
	end

	assign status       = status_q;
	assign answer_valid = ans_valid_q;
	assign answer_value = ans_q;
	assign stack_depth  = count_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("entry count beyond stack depth");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DECODE))
		else $error("accepted transaction not decoded");

	a_alu_owned: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_ALU))
		else $error("arithmetic unit finished outside wait state");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DECODE && state_q != S_POP_RD && state_q != S_ALU)
		|=> $stable(count_q))
		else $error("entry count changed outside update states");

endmodule
`default_nettype wire
